@@ src/utf8_stream_decoder_macros.svh @@
// Assertion macros shared by the decoder modules.
// Define ASSERT_OFF to compile all checks away.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define UTF8SD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Condition must never be true at a clock edge outside reset.
`define UTF8SD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define UTF8SD_ASSERT(lbl, clk, rst_n, prop)
`define UTF8SD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/utf8sd_pkg.sv @@
package utf8sd_pkg;

    localparam int QUEUE_DEPTH = 4;

    // output_format codes; the unused code behaves as codepoint output
    localparam logic [1:0] FMT_CODEPOINT = 2'd0;
    localparam logic [1:0] FMT_UTF16     = 2'd1;
    localparam logic [1:0] FMT_LATIN1    = 2'd2;

    localparam logic [20:0] CP_REPL       = 21'h00FFFD;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_LOW_BASE   = 21'h00DC00;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [20:0] CP_MIN3       = 21'h000800;
    localparam logic [20:0] CP_LATIN1_MAX = 21'h0000FF;
    localparam logic [20:0] CP_QMARK      = 21'h00003F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [20:0] out_unit;
        logic        was_replaced;
        logic        last_of_run;
    } out_item_t;

    // One byte's worth of work for the back end: replacements for a broken
    // or truncated sequence, then at most one codepoint, then at most one
    // replacement for a lead cut off by end of text.
    typedef struct packed {
        logic [1:0]  pre_cnt;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        main_repl;
        logic        post_repl;
    } job_t;

endpackage

@@ src/utf8_stream_decoder.sv @@
// Channel   Direction  Handshake           Payload
// input     in         push / full         in_item  (text_byte, end_of_text)
// result    out        empty / pop         out_item (out_unit, was_replaced, last_of_run)
// config    in         cfg_we              cfg_data (output_format)
//
// Takes one byte per cycle while the job queue has room; each byte is decoded
// in the cycle of its beat, and a byte that gives results pushes one job.
// Results leave at one per cycle while the output register is empty or popped; a byte's
// results hold the back end until its last leaves; full rises once QueueDepth jobs pile
// up behind a burst or stalled pop. Results reach out_item via queue and output register.
// rst_n clears the pending sequence, queue and output register; format resets to codepoint.
module utf8_stream_decoder
    import utf8sd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item,
    input  logic      cfg_we,
    input  logic [1:0] cfg_data
);

    logic [1:0] output_format_reg;
    logic       accept;
    logic       job_push;
    job_t       push_job;
    job_t       head_job;
    logic       q_empty;
    logic       q_pop;

    // Configuration: the user must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_format_reg <= FMT_CODEPOINT;
        end
        else if (cfg_we)
        begin
            output_format_reg <= cfg_data;
        end
    end

    // An input beat completes when the queue can take a job.
    assign accept = push && !full;

    // Front end: track the pending sequence, classify the byte, build its job.
    utf8sd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_item  (in_item),
        .job_push (job_push),
        .job      (push_job)
    );

    // Job queue decouples byte intake from result delivery.
    utf8sd_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // Back end: expand each job into result beats, format them, register them.
    utf8sd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .output_format (output_format_reg),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_item      (out_item)
    );

endmodule

@@ src/utf8sd_queue.sv @@
`include "utf8_stream_decoder_macros.svh"

module utf8sd_queue
    import utf8sd_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    job_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full     = (count_reg == CntFull);
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `UTF8SD_ASSERT(a_count_bound, clk, rst_n, (count_reg <= CntFull))
    `UTF8SD_NEVER(a_pop_when_empty, clk, rst_n, (pop && empty))

endmodule

@@ src/utf8sd_front.sv @@
`include "utf8_stream_decoder_macros.svh"

module utf8sd_front
    import utf8sd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t in_item,
    output logic     job_push,
    output job_t     job
);

    logic [7:0]  lead_reg;
    logic [7:0]  lead_next;
    logic        in_seq_reg;
    logic        in_seq_next;
    logic [1:0]  cont_cnt_reg;
    logic [1:0]  cont_cnt_next;
    logic [20:0] gathered_reg;
    logic [20:0] gathered_next;

    // Continuations a lead byte asks for; zero for anything that is no lead.
    function automatic logic [1:0] lead_conts(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b[7:5] == 3'b110)
        begin
            n = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            n = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [20:0] lead_payload(input logic [7:0] b, input logic [1:0] n);
        logic [20:0] p;
        unique case (n)
            2'd1:    p = {16'd0, b[4:0]};
            2'd2:    p = {17'd0, b[3:0]};
            default: p = {18'd0, b[2:0]};
        endcase
        return p;
    endfunction

    // Overlong, surrogate or out-of-range completed sequence.
    function automatic logic seq_bad(input logic [7:0] lead, input logic [1:0] need,
                                     input logic [20:0] cp);
        logic bad;
        unique case (need)
            2'd1:    bad = (lead[4:1] == 4'd0);
            2'd2:    bad = (cp < CP_MIN3) || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
            default: bad = (cp < CP_SUPP_BASE) || (cp > CP_MAX);
        endcase
        return bad;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic        eot;
        logic        is_cont;
        logic [1:0]  need;
        logic [1:0]  new_conts;
        logic [1:0]  cnt_inc;
        logic [20:0] g_shift;
        logic        bad;

        b         = in_item.text_byte;
        eot       = in_item.end_of_text;
        is_cont   = (b[7:6] == 2'b10);
        need      = lead_conts(lead_reg);
        new_conts = lead_conts(b);
        cnt_inc   = cont_cnt_reg + 2'd1;
        g_shift   = {gathered_reg[14:0], b[5:0]};
        bad       = seq_bad(lead_reg, need, g_shift);

        lead_next     = lead_reg;
        in_seq_next   = in_seq_reg;
        cont_cnt_next = cont_cnt_reg;
        gathered_next = gathered_reg;
        job           = '0;

        if (in_seq_reg && is_cont)
        begin
            if (cnt_inc >= need)
            begin
                // sequence complete
                job.main_valid = 1'b1;
                job.main_cp    = bad ? CP_REPL : g_shift;
                job.main_repl  = bad;
                lead_next      = '0;
                in_seq_next    = 1'b0;
                cont_cnt_next  = '0;
                gathered_next  = '0;
            end
            else if (eot)
            begin
                // truncated: one replacement for the lead and each continuation
                job.pre_cnt   = cnt_inc + 2'd1;
                lead_next     = '0;
                in_seq_next   = 1'b0;
                cont_cnt_next = '0;
                gathered_next = '0;
            end
            else
            begin
                cont_cnt_next = cnt_inc;
                gathered_next = g_shift;
            end
        end
        else
        begin
            if (in_seq_reg)
            begin
                job.pre_cnt = cnt_inc;
            end
            lead_next     = '0;
            in_seq_next   = 1'b0;
            cont_cnt_next = '0;
            gathered_next = '0;
            if (!b[7])
            begin
                job.main_valid = 1'b1;
                job.main_cp    = {13'd0, b};
            end
            else if (new_conts != 2'd0)
            begin
                if (eot)
                begin
                    job.post_repl = 1'b1;
                end
                else
                begin
                    lead_next     = b;
                    in_seq_next   = 1'b1;
                    gathered_next = lead_payload(b, new_conts);
                end
            end
            else
            begin
                job.main_valid = 1'b1;
                job.main_cp    = CP_REPL;
                job.main_repl  = 1'b1;
            end
        end
    end

    // Drop bytes that only extend a sequence: they give the back end nothing.
    assign job_push = accept && ((job.pre_cnt != 2'd0) || job.main_valid || job.post_repl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= '0;
            in_seq_reg   <= 1'b0;
            cont_cnt_reg <= '0;
            gathered_reg <= '0;
        end
        else if (accept)
        begin
            lead_reg     <= lead_next;
            in_seq_reg   <= in_seq_next;
            cont_cnt_reg <= cont_cnt_next;
            gathered_reg <= gathered_next;
        end
    end

    `UTF8SD_ASSERT(a_seq_count, clk, rst_n, (in_seq_reg |-> (cont_cnt_reg < lead_conts(lead_reg))))

endmodule

@@ src/utf8sd_back.sv @@
`include "utf8_stream_decoder_macros.svh"

module utf8sd_back
    import utf8sd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] output_format,
    input  job_t      head_job,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic [1:0] pre_done_reg;
    logic [1:0] pre_done_next;
    logic       hi_done_reg;
    logic       hi_done_next;
    logic       main_done_reg;
    logic       main_done_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  unit;
    logic       advance;
    logic       emit;

    function automatic logic [20:0] conv(input logic [20:0] cp, input logic [1:0] fmt);
        logic [20:0] u;
        case (fmt)
            FMT_LATIN1: u = (cp <= CP_LATIN1_MAX) ? cp : CP_QMARK;
            default:    u = cp;
        endcase
        return u;
    endfunction

    assign advance = !out_valid_reg || pop;
    assign emit    = !q_empty && advance;

    always_comb
    begin
        logic        pre_left;
        logic        split;
        logic [20:0] diff;

        pre_left = (pre_done_reg != head_job.pre_cnt);
        split    = (output_format == FMT_UTF16) && (head_job.main_cp >= CP_SUPP_BASE);
        diff     = head_job.main_cp - CP_SUPP_BASE;

        pre_done_next  = pre_done_reg;
        hi_done_next   = hi_done_reg;
        main_done_next = main_done_reg;
        unit           = '0;

        if (pre_left)
        begin
            unit.out_unit     = conv(CP_REPL, output_format);
            unit.was_replaced = 1'b1;
            unit.last_of_run  = (2'(pre_done_reg + 2'd1) == head_job.pre_cnt)
                                && !head_job.main_valid && !head_job.post_repl;
            pre_done_next     = pre_done_reg + 2'd1;
        end
        else if (head_job.main_valid && !main_done_reg)
        begin
            unit.was_replaced = head_job.main_repl;
            if (split && !hi_done_reg)
            begin
                unit.out_unit    = CP_SURR_LO | {11'd0, diff[19:10]};
                unit.last_of_run = 1'b0;
                hi_done_next     = 1'b1;
            end
            else
            begin
                unit.out_unit    = split ? (CP_LOW_BASE | {11'd0, diff[9:0]})
                                         : conv(head_job.main_cp, output_format);
                unit.last_of_run = !head_job.post_repl;
                hi_done_next     = 1'b0;
                main_done_next   = 1'b1;
            end
        end
        else
        begin
            unit.out_unit     = conv(CP_REPL, output_format);
            unit.was_replaced = 1'b1;
            unit.last_of_run  = 1'b1;
        end

        if (unit.last_of_run)
        begin
            pre_done_next  = '0;
            hi_done_next   = 1'b0;
            main_done_next = 1'b0;
        end
    end

    assign q_pop    = emit && unit.last_of_run;
    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_done_reg  <= '0;
            hi_done_reg   <= 1'b0;
            main_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                pre_done_reg  <= pre_done_next;
                hi_done_reg   <= hi_done_next;
                main_done_reg <= main_done_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= unit;
        end
    end

    `UTF8SD_ASSERT(a_idle_counters, clk, rst_n,
        (q_empty |-> ((pre_done_reg == 2'd0) && !hi_done_reg && !main_done_reg)))
    `UTF8SD_NEVER(a_half_after_main, clk, rst_n, (hi_done_reg && main_done_reg))

endmodule
